@@ hw/rtl/tlvd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the TLV stream deframer: shared constants, result codes and the
// queue entry passed from the parsing front end to the output back end.
// No dependencies.
package tlvd_pkg;

  // Default build parameters
  localparam int MAX_MESSAGE_BYTES_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF       = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_TYPE_CODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORDS   = 1'd1;
  localparam logic [7:0] END_TYPE_CODE_RESET = 8'd0;
  localparam logic [7:0] MAX_RECORDS_RESET   = 8'd64;

  // Result kinds
  localparam logic [1:0] KIND_RECORD    = 2'd0;
  localparam logic [1:0] KIND_STATUS_OK = 2'd1;
  localparam logic [1:0] KIND_STATUS_ERR = 2'd2;

  // One queue entry: at most one record and at most one status per byte
  typedef struct packed {
    logic        has_rec;
    logic        has_stat;
    logic        stat_err;
    logic [7:0]  rec_type;
    logic [15:0] rec_len;
    logic [15:0] rec_off;
    logic [7:0]  rec_idx;
    logic [7:0]  stat_count;
  } tlvd_entry_t;

endpackage

@@ hw/rtl/tlvd_front.sv @@
`timescale 1ns / 1ps
// Front end of the TLV deframer: accepts bytes, tracks the element parse state
// and pushes one queue entry per byte that yields a record or a status.
// Depends on tlvd_pkg.
module tlvd_front import tlvd_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [7:0]  end_type_code,
  input  logic [7:0]  max_records,
  output logic        push,
  output tlvd_entry_t push_data
);

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);

  typedef enum logic [4:0] {
    PH_TYPE   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_VALUE  = 5'b01000,
    PH_SKIP   = 5'b10000
  } tlvd_phase_t;

  tlvd_phase_t      phase, phase_next;
  logic [7:0]       held_type, held_type_next;
  logic [15:0]      held_length, held_length_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic [OFF_W-1:0] message_offset, message_offset_next;
  logic [15:0]      value_start, value_start_next;
  logic [7:0]       records_seen, records_seen_next;
  logic             finished, finished_next;
  logic             error, error_next;

  logic        emit;
  logic        bad;
  logic [17:0] vs;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  assign vs       = 18'(message_offset) + 18'd1;
  assign len_full = {held_length[15:8], byte_value};
  assign left_dec = bytes_left - 16'd1;

  // Parse step for one accepted byte
  always_comb begin
    phase_next          = phase;
    held_type_next      = held_type;
    held_length_next    = held_length;
    bytes_left_next     = bytes_left;
    message_offset_next = message_offset;
    value_start_next    = value_start;
    records_seen_next   = records_seen;
    finished_next       = finished;
    error_next          = error;
    emit                = 1'b0;
    bad                 = 1'b0;

    if (!finished && !error) begin
      if (message_offset >= OFF_W'(MAX_MESSAGE_BYTES)) begin
        error_next = 1'b1;
      end else begin
        message_offset_next = message_offset + OFF_W'(1);
        case (phase)
          PH_LEN_HI: begin
            held_length_next = {byte_value, 8'h00};
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            held_length_next = len_full;
            bytes_left_next  = len_full;
            phase_next       = PH_TYPE;
            if (vs > 18'd65535) begin
              error_next = 1'b1;
            end else begin
              value_start_next = vs[15:0];
              if (held_type == end_type_code) begin
                if (len_full == 16'd0) finished_next = 1'b1;
                else phase_next = PH_SKIP;
              end else if (records_seen >= max_records) begin
                error_next = 1'b1;
              end else if (len_full == 16'd0) begin
                emit = 1'b1;
              end else begin
                phase_next = PH_VALUE;
              end
            end
          end
          PH_VALUE: begin
            bytes_left_next = left_dec;
            if (left_dec == 16'd0) begin
              emit       = 1'b1;
              phase_next = PH_TYPE;
            end
          end
          PH_SKIP: begin
            bytes_left_next = left_dec;
            if (left_dec == 16'd0) begin
              finished_next = 1'b1;
              phase_next    = PH_TYPE;
            end
          end
          default: begin
            // expect type byte; stray codes behave the same
            held_type_next = byte_value;
            phase_next     = PH_LEN_HI;
          end
        endcase
      end
    end

    if (emit) records_seen_next = records_seen + 8'd1;

    // Message end: a value or skip still open is a cut-off
    bad = error_next || (!finished_next &&
          (phase_next == PH_VALUE || phase_next == PH_SKIP));
  end

  // Queue entry for this byte
  always_comb begin
    push                 = accept && (emit || last_byte);
    push_data.has_rec    = emit;
    push_data.has_stat   = last_byte;
    push_data.stat_err   = bad;
    push_data.rec_type   = held_type;
    push_data.rec_len    = held_length_next;
    push_data.rec_off    = value_start_next;
    push_data.rec_idx    = records_seen;
    push_data.stat_count = records_seen_next;
  end

  // State update; the final byte returns everything to its reset value
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase          <= PH_TYPE;
      held_type      <= '0;
      held_length    <= '0;
      bytes_left     <= '0;
      message_offset <= '0;
      value_start    <= '0;
      records_seen   <= '0;
      finished       <= 1'b0;
      error          <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      held_type      <= held_type_next;
      held_length    <= held_length_next;
      bytes_left     <= bytes_left_next;
      message_offset <= message_offset_next;
      value_start    <= value_start_next;
      records_seen   <= records_seen_next;
      finished       <= finished_next;
      error          <= error_next;
    end
  end

endmodule

@@ hw/rtl/tlvd_queue.sv @@
`timescale 1ns / 1ps
// Short entry queue between the deframer front and back ends.
// Depth must be a power of two. Depends on tlvd_pkg.
module tlvd_queue import tlvd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tlvd_entry_t push_data,
  input  logic        pop,
  output logic        head_valid,
  output tlvd_entry_t head_data,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlvd_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

@@ hw/rtl/tlvd_back.sv @@
`timescale 1ns / 1ps
// Back end of the TLV deframer: turns queue entries into results in the output
// register, record first and status second when an entry carries both.
// Depends on tlvd_pkg.
module tlvd_back import tlvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  tlvd_entry_t head_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  record_type,
  output logic [15:0] record_length,
  output logic [15:0] value_offset,
  output logic [7:0]  record_count,
  output logic        final_result
);

  logic load;
  logic send_rec;
  logic sub, sub_next;

  assign load     = head_valid && (!out_valid || !out_stall);
  assign send_rec = head_data.has_rec && !sub;

  // Pop once the entry's last result is loaded
  always_comb begin
    pop      = 1'b0;
    sub_next = sub;
    if (load) begin
      if (send_rec && head_data.has_stat) begin
        sub_next = 1'b1;
      end else begin
        pop      = 1'b1;
        sub_next = 1'b0;
      end
    end
  end

  // Output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      sub <= sub_next;
      if (load)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (send_rec) begin
        result_kind   <= KIND_RECORD;
        record_type   <= head_data.rec_type;
        record_length <= head_data.rec_len;
        value_offset  <= head_data.rec_off;
        record_count  <= head_data.rec_idx;
        final_result  <= !head_data.has_stat;
      end else begin
        result_kind   <= head_data.stat_err ? KIND_STATUS_ERR : KIND_STATUS_OK;
        record_type   <= '0;
        record_length <= '0;
        value_offset  <= '0;
        record_count  <= head_data.stat_count;
        final_result  <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tlv_stream_deframer_core.sv @@
`timescale 1ns / 1ps
// TLV stream deframer top level: one message byte per transfer in, records
// and a final status per message out.
// Throughput: one byte per cycle unless the queue is full (in_stall); a final
// byte that also completes a record gives two results, which leave one after
// the other from the output stage. The queue is written at the input transfer
// edge, the output register later from the queue head. Sync active-high reset.
module tlv_stream_deframer_core import tlvd_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             byte_value,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [7:0]             record_type,
  output logic [15:0]            record_length,
  output logic [15:0]            value_offset,
  output logic [7:0]             record_count,
  output logic                   final_result
);

  logic [7:0]  end_type_code;
  logic [7:0]  max_records;
  logic        accept;
  logic        push, pop, q_full, head_valid;
  tlvd_entry_t push_data, head_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      end_type_code <= END_TYPE_CODE_RESET;
      max_records   <= MAX_RECORDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_END_TYPE_CODE: end_type_code <= cfg_data;
        CFG_MAX_RECORDS:   max_records   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tlvd_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_value   (byte_value),
    .last_byte    (last_byte),
    .end_type_code(end_type_code),
    .max_records  (max_records),
    .push         (push),
    .push_data    (push_data)
  );

  tlvd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data),
    .full      (q_full)
  );

  tlvd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .record_type  (record_type),
    .record_length(record_length),
    .value_offset (value_offset),
    .record_count (record_count),
    .final_result (final_result)
  );

  // A record that is not final is followed at once by its status
  a_rec_then_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && result_kind == KIND_RECORD && !final_result
    |=> out_valid && result_kind != KIND_RECORD)
    else $error("record marked non-final not followed by status");

  // Status results always close the byte's results
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_RECORD |-> final_result)
    else $error("status result without final mark");

  // Nothing leaves the block straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ tb/tlv_stream_deframer_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tlv_stream_deframer_core: random and directed byte
// streams against a cycle-free model of the TLV parser held in a small class.
// Depends on tlvd_pkg and the core RTL only.
module tlv_stream_deframer_core_test;
  import tlvd_pkg::*;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SEGMENT_BYTES = 300;

  typedef enum logic [2:0] {
    ST_TYPE, ST_LEN_HI, ST_LEN_LO, ST_VALUE, ST_SKIP
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rec_type;
    logic [15:0] rec_len;
    logic [15:0] rec_off;
    logic [7:0]  rec_count;
    logic        rec_final;
  } tlv_result_t;

  // Parser model plus the queue of results still owed by the block
  class tlv_parse_tracker;
    tlv_result_t  pending_results[$];
    int unsigned  mismatches;
    logic [7:0]   end_code;
    logic [7:0]   rec_limit;
    parse_state_t state;
    logic [7:0]   cur_type;
    logic [15:0]  cur_len;
    logic [15:0]  left;
    logic [15:0]  val_start;
    logic [16:0]  msg_offset;
    logic [7:0]   rec_seen;
    logic         done_flag;
    logic         err_flag;

    function new();
      end_code   = END_TYPE_CODE_RESET;
      rec_limit  = MAX_RECORDS_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      state      = ST_TYPE;
      cur_type   = '0;
      cur_len    = '0;
      left       = '0;
      val_start  = '0;
      msg_offset = '0;
      rec_seen   = '0;
      done_flag  = 1'b0;
      err_flag   = 1'b0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_END_TYPE_CODE: end_code = data;
        CFG_MAX_RECORDS:   rec_limit = data;
        default: ;
      endcase
    endfunction

    // Advance the parser by one accepted byte and queue what it owes
    function void take_byte(logic [7:0] value, logic is_last);
      tlv_result_t r;
      logic [16:0] idx;
      logic [16:0] vs;
      logic        emit;
      logic        bad;
      emit = 1'b0;
      if (!done_flag && !err_flag) begin
        if (msg_offset >= 17'd65536) begin
          err_flag = 1'b1;
        end else begin
          idx = msg_offset;
          msg_offset = msg_offset + 17'd1;
          case (state)
            ST_LEN_HI: begin
              cur_len = {value, 8'h00};
              state = ST_LEN_LO;
            end
            ST_LEN_LO: begin
              vs = idx + 17'd1;
              cur_len = cur_len | {8'h00, value};
              left = cur_len;
              state = ST_TYPE;
              if (vs > 17'h0FFFF) begin
                err_flag = 1'b1;
              end else begin
                val_start = vs[15:0];
                if (cur_type == end_code) begin
                  if (cur_len == 16'd0) done_flag = 1'b1;
                  else state = ST_SKIP;
                end else if (rec_seen >= rec_limit) begin
                  err_flag = 1'b1;
                end else if (cur_len == 16'd0) begin
                  emit = 1'b1;
                end else begin
                  state = ST_VALUE;
                end
              end
            end
            ST_VALUE: begin
              left = left - 16'd1;
              if (left == 16'd0) begin
                emit = 1'b1;
                state = ST_TYPE;
              end
            end
            ST_SKIP: begin
              left = left - 16'd1;
              if (left == 16'd0) begin
                done_flag = 1'b1;
                state = ST_TYPE;
              end
            end
            default: begin
              cur_type = value;
              state = ST_LEN_HI;
            end
          endcase
          if (emit) begin
            r.kind      = KIND_RECORD;
            r.rec_type  = cur_type;
            r.rec_len   = cur_len;
            r.rec_off   = val_start;
            r.rec_count = rec_seen;
            r.rec_final = !is_last;
            pending_results.push_back(r);
            rec_seen = rec_seen + 8'd1;
          end
        end
      end
      // final byte: status transfer, then start a fresh message
      if (is_last) begin
        bad = err_flag;
        if (!done_flag && !err_flag && (state == ST_VALUE || state == ST_SKIP)) bad = 1'b1;
        r.kind      = bad ? KIND_STATUS_ERR : KIND_STATUS_OK;
        r.rec_type  = '0;
        r.rec_len   = '0;
        r.rec_off   = '0;
        r.rec_count = rec_seen;
        r.rec_final = 1'b1;
        pending_results.push_back(r);
        restart();
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_result(tlv_result_t got);
      tlv_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d count %0d", got.kind, got.rec_count);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("result_kind", want.kind, got.kind);
      check_field("record_type", want.rec_type, got.rec_type);
      check_field("record_length", want.rec_len, got.rec_len);
      check_field("value_offset", want.rec_off, got.rec_off);
      check_field("record_count", want.rec_count, got.rec_count);
      check_field("final_result", want.rec_final, got.rec_final);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             byte_value;
  logic                   last_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             result_kind;
  logic [7:0]             record_type;
  logic [15:0]            record_length;
  logic [15:0]            value_offset;
  logic [7:0]             record_count;
  logic                   final_result;

  tlv_parse_tracker sb = new();
  logic [7:0]       msg_bytes[$];
  tlv_result_t      seen_result;
  int               send_idle_pct = 28;
  int               recv_idle_pct = 46;
  logic             hold_req = 1'b0;
  int               quiet_cycles = 0;

  tlv_stream_deframer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .record_type   (record_type),
    .record_length (record_length),
    .value_offset  (value_offset),
    .record_count  (record_count),
    .final_result  (final_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result = {result_kind, record_type, record_length, value_offset,
                     record_count, final_result};
      sb.compare_result(seen_result);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // One byte transfer, with random idle cycles in front
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= value;
    last_byte  <= is_last;
    do @(posedge clk); while (in_stall);
    sb.take_byte(value, is_last);
    @(negedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  // Header plus random value bytes
  task automatic append_element(input logic [7:0] elem_type, input logic [15:0] len);
    msg_bytes.push_back(elem_type);
    msg_bytes.push_back(len[15:8]);
    msg_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Both registers, back to back; block must be idle
  task automatic write_regs(input logic [7:0] end_code, input logic [7:0] max_rec);
    cfg_write <= 1'b1;
    cfg_index <= CFG_END_TYPE_CODE;
    cfg_data  <= end_code;
    @(posedge clk);
    sb.set_register(CFG_END_TYPE_CODE, end_code);
    @(negedge clk);
    cfg_index <= CFG_MAX_RECORDS;
    cfg_data  <= max_rec;
    @(posedge clk);
    sb.set_register(CFG_MAX_RECORDS, max_rec);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stop sending until every owed result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int         sent;
    int         pick;
    int         cut;
    logic [7:0] seg_end [6];
    logic [7:0] seg_max [6];
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = CFG_END_TYPE_CODE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    byte_value = '0;
    last_byte  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset register values: record then end element
    msg_bytes = '{8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    // record completing on the final byte: two results
    msg_bytes = '{8'h10, 8'h00, 8'h01, 8'hAB};
    send_message();
    // value cut off by the message end
    msg_bytes = '{8'h20, 8'h00, 8'h05, 8'h01};
    send_message();
    // empty record, then a partial trailing header
    msg_bytes = '{8'h30, 8'h00, 8'h00, 8'h31};
    send_message();
    // end element whose skipped value is cut off
    msg_bytes = '{8'h00, 8'h00, 8'h02, 8'hEE};
    send_message();
    msg_bytes = '{8'h00};
    send_message();
    wait_for_drain();

    // No records allowed: error, then ignored bytes; end element still fine
    write_regs(8'h7E, 8'd0);
    msg_bytes = '{8'h01, 8'h00, 8'h00, 8'h7E};
    send_message();
    msg_bytes = '{8'h7E, 8'h00, 8'h00};
    send_message();
    wait_for_drain();

    seg_end = '{8'hFF, 8'h00, 8'h5A, 8'($urandom_range(255)), 8'h01,
                8'($urandom_range(255))};
    seg_max = '{8'd255, 8'd0, 8'd3, 8'($urandom_range(8)), 8'd1,
                8'($urandom_range(12))};

    // Random messages; idle pattern changes every two segments
    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 46 : 0;
      recv_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 28 : 0;
      write_regs(seg_end[seg], seg_max[seg]);
      if (seg == 0) hold_req <= 1'b1;
      sent = 0;
      while (sent < SEGMENT_BYTES) begin
        msg_bytes = {};
        pick = $urandom_range(99);
        if (pick < 85) begin
          // well-formed elements, mostly short values
          repeat ($urandom_range(5)) begin
            append_element(8'($urandom_range(255)),
                           16'(($urandom_range(9) < 8) ? $urandom_range(4)
                                                       : $urandom_range(40)));
          end
          if ($urandom_range(9) < 7) begin
            append_element(sb.end_code, 16'($urandom_range(2)));
            if ($urandom_range(9) < 3) begin
              repeat ($urandom_range(4, 1)) msg_bytes.push_back(8'($urandom_range(255)));
            end
          end
          // broken: chop the message short
          if (pick >= 70 && msg_bytes.size() > 1) begin
            cut = $urandom_range(msg_bytes.size() - 1, 1);
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
          end
        end else begin
          repeat ($urandom_range(12, 1)) msg_bytes.push_back(8'($urandom_range(255)));
        end
        if (msg_bytes.size() == 0) msg_bytes.push_back(8'($urandom_range(255)));
        send_message();
        sent += msg_bytes.size();
      end
      wait_for_drain();
    end

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tlvd_pkg.sv
hw/rtl/tlvd_front.sv
hw/rtl/tlvd_queue.sv
hw/rtl/tlvd_back.sv
hw/rtl/tlv_stream_deframer_core.sv
tb/tlv_stream_deframer_core_test.sv
